// ===== hw/rtl/hsr_pkg.sv =====
`default_nettype none

package hsr_pkg;

  // Number of cells in the chain and the widths that follow from it.
  localparam int MAX_LEN = 128;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int VAL_W   = 32;
  localparam int SUM_W   = VAL_W + 2;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_READ  = 1'b1
  } hsr_cmd_t;

  typedef enum logic [1:0] {
    REG_LENGTH = 2'd0,
    REG_TOL    = 2'd1,
    REG_HEAT   = 2'd2
  } hsr_reg_t;

  // Operation applied to every cell in the same cycle.
  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_CALC   = 3'd2,
    OP_COMMIT = 3'd3,
    OP_ROT    = 3'd4
  } hsr_op_t;

  typedef struct packed {
    hsr_op_t          op;
    logic [VAL_W-1:0] tol;
  } hsr_cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hsr_cell.sv =====
`default_nettype none

// One element of the vector. The stencil value is registered by a calc
// operation and committed, together with its change flag, by a commit.
module hsr_cell
  import hsr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire hsr_cell_ctl_t    ctl,
  input  wire logic             interior,
  input  wire logic [VAL_W-1:0] load_val,
  input  wire logic [VAL_W-1:0] left_val,
  input  wire logic [VAL_W-1:0] right_val,
  input  wire logic [VAL_W-1:0] rot_in,
  output logic      [VAL_W-1:0] val,
  output logic                  changed
);

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] nv_r;
  logic             changed_r;
  logic [SUM_W-1:0] sum;
  logic [VAL_W-1:0] diff;

  assign sum  = {2'b00, left_val} + {1'b0, val_r, 1'b0} + {2'b00, right_val};
  assign diff = (nv_r >= val_r) ? (nv_r - val_r) : (val_r - nv_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      changed_r <= 1'b0;
    end else begin
      case (ctl.op)
        OP_LOAD:   changed_r <= 1'b0;
        OP_COMMIT: changed_r <= interior && (diff > ctl.tol);
        default:   changed_r <= changed_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD:   val_r <= load_val;
      OP_CALC:   nv_r  <= sum[SUM_W-1:2];
      OP_COMMIT: begin
        if (interior) begin
          val_r <= nv_r;
        end
      end
      OP_ROT:    val_r <= rot_in;
      default:   ;
    endcase
  end

  assign val     = val_r;
  assign changed = changed_r;

endmodule

`default_nettype wire

// ===== hw/rtl/hsr_chain.sv =====
`default_nettype none

// Row of cells. Each cell sees its two neighbors for the stencil, and the
// row closes into a ring for rotation so cell 0 can present any element.
module hsr_chain
  import hsr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire hsr_cell_ctl_t    ctl,
  input  wire logic [LEN_W-1:0] run_len,
  input  wire logic [VAL_W-1:0] edge_val,
  output logic      [VAL_W-1:0] head_val,
  output logic                  all_stable
);

  logic [VAL_W-1:0]   vals     [MAX_LEN];
  logic [MAX_LEN-1:0] changed;
  logic [MAX_LEN-1:0] interior;

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    logic [VAL_W-1:0] left_v;
    logic [VAL_W-1:0] right_v;
    logic [VAL_W-1:0] rot_v;
    logic [VAL_W-1:0] load_v;

    if (i == 0) begin : g_first
      assign left_v      = '0;
      assign load_v      = edge_val;
      assign interior[i] = 1'b0;
    end else begin : g_rest
      assign left_v      = vals[i-1];
      assign load_v      = '0;
      assign interior[i] = (LEN_W'(i + 1) < run_len);
    end

    if (i == MAX_LEN - 1) begin : g_last
      assign right_v = '0;
      assign rot_v   = vals[0];
    end else begin : g_mid
      assign right_v = vals[i+1];
      assign rot_v   = vals[i+1];
    end

    hsr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .interior  (interior[i]),
      .load_val  (load_v),
      .left_val  (left_v),
      .right_val (right_v),
      .rot_in    (rot_v),
      .val       (vals[i]),
      .changed   (changed[i])
    );
  end

  assign head_val   = vals[0];
  assign all_stable = ~|changed;

endmodule

`default_nettype wire

// ===== hw/rtl/heat_stencil_relaxation.sv =====
`default_nettype none

// Channel  Direction  Accepted when           Payload
// in_      input      in_tvalid & in_tready   tuser: command; tdata: index
// out_     output     out_tvalid & out_tready tdata: value, passes, pass_cap_hit
// cfg_     input      cfg_we                  cfg_addr selects, cfg_wdata holds data
//
// A start loads the vector, then runs Jacobi passes, each a compute step
// followed by a commit step, then a final check step and a step that
// posts the result. A read rotates the ring of cells once all the way
// round, captures the requested element as it passes cell 0, then posts it.
// Reset (synchronous, active low) clears the control state and the pass count
// and returns the configuration registers to their reset values; vector
// contents are undefined until a start loads them.
// A result waiting on out_tready does not stop a new item from being taken;
// only posting the next result waits for the output register to free up.
module heat_stencil_relaxation
  import hsr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input items.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [6:0] index, [7] zero fill
  input  wire logic [0:0]  in_tuser,   // [0] command
  // Result items.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // [31:0] value, [63:32] passes,
                                       // [64] pass_cap_hit, [71:65] zero fill
  // Configuration writes.
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_COMMIT,
    S_READ,
    S_FINISH
  } state_t;

  localparam logic [VAL_W-1:0] PASS_MAX = '1;

  state_t           state_r;
  logic [7:0]       len_cfg_r;
  logic [31:0]      tol_cfg_r;
  logic [15:0]      heat_cfg_r;

  logic [LEN_W-1:0] run_len_r;
  logic [VAL_W-1:0] pass_r;
  logic             cap_r;
  logic             chk_valid_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] rot_r;
  logic [VAL_W-1:0] rd_r;
  logic             is_read_r;

  logic             out_valid_r;
  logic [VAL_W-1:0] out_value_r;
  logic [VAL_W-1:0] out_passes_r;
  logic             out_cap_r;

  hsr_cell_ctl_t    cell_ctl;
  logic [VAL_W-1:0] head_val;
  logic             all_stable;
  logic             in_fire;
  logic [LEN_W-1:0] len_eff;
  logic [VAL_W-1:0] edge_val;
  logic             run_done;
  logic             rd_in_range;
  logic             post_result;

  // Configuration registers; the user must write them only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r  <= 8'd100;
      tol_cfg_r  <= 32'd6554;
      heat_cfg_r <= 16'd100;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LENGTH: len_cfg_r  <= cfg_wdata[7:0];
        REG_TOL:    tol_cfg_r  <= cfg_wdata;
        REG_HEAT:   heat_cfg_r <= cfg_wdata[15:0];
        default:    ;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Length clamped to the range the chain supports.
  assign len_eff = (len_cfg_r < 8'd2)            ? LEN_W'(2) :
                   (len_cfg_r > 8'(MAX_LEN))     ? LEN_W'(MAX_LEN) :
                                                   LEN_W'(len_cfg_r);
  assign edge_val = {heat_cfg_r, 16'h0000};

  // A run ends once a committed pass has been checked and was either stable
  // or left the pass counter saturated.
  assign run_done    = chk_valid_r && (all_stable || (pass_r == PASS_MAX));
  assign rd_in_range = ({1'b0, idx_r} < run_len_r);

  // The finished item moves into the output register once that is free or
  // being emptied in this cycle.
  assign post_result = (state_r == S_FINISH) && (!out_valid_r || out_tready);

  always_comb begin
    cell_ctl.tol = tol_cfg_r;
    cell_ctl.op  = OP_HOLD;
    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_tuser[0] == CMD_START)) begin
          cell_ctl.op = OP_LOAD;
        end
      end
      S_CALC:   cell_ctl.op = OP_CALC;
      S_COMMIT: cell_ctl.op = OP_COMMIT;
      S_READ:   cell_ctl.op = OP_ROT;
      default:  cell_ctl.op = OP_HOLD;
    endcase
  end

  hsr_chain u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (cell_ctl),
    .run_len    (run_len_r),
    .edge_val   (edge_val),
    .head_val   (head_val),
    .all_stable (all_stable)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      run_len_r    <= '0;
      pass_r       <= '0;
      cap_r        <= 1'b0;
      chk_valid_r  <= 1'b0;
      is_read_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
      rot_r        <= '0;
      rd_r         <= '0;
      out_value_r  <= '0;
      out_passes_r <= '0;
      out_cap_r    <= 1'b0;
    end else begin
      if (post_result) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_tuser[0] == CMD_START) begin
              run_len_r   <= len_eff;
              pass_r      <= '0;
              cap_r       <= 1'b0;
              chk_valid_r <= 1'b0;
              is_read_r   <= 1'b0;
              state_r     <= S_CALC;
            end else begin
              idx_r     <= in_tdata[IDX_W-1:0];
              rot_r     <= '0;
              is_read_r <= 1'b1;
              state_r   <= S_READ;
            end
          end
        end
        S_CALC: begin
          if (run_done) begin
            cap_r   <= !all_stable;
            state_r <= S_FINISH;
          end else begin
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (pass_r != PASS_MAX) begin
            pass_r <= pass_r + VAL_W'(1);
          end
          chk_valid_r <= 1'b1;
          state_r     <= S_CALC;
        end
        S_READ: begin
          // Cell 0 holds element k during rotation step k.
          if (rot_r == idx_r) begin
            rd_r <= head_val;
          end
          rot_r <= rot_r + IDX_W'(1);
          if (rot_r == IDX_W'(MAX_LEN - 1)) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (post_result) begin
            out_value_r  <= (is_read_r && rd_in_range) ? rd_r : '0;
            out_passes_r <= pass_r;
            out_cap_r    <= cap_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0000000, out_cap_r, out_passes_r, out_value_r};

  // The saturation flag is only ever set together with a full pass counter.
  a_cap_full: assert property (@(posedge clk) disable iff (!rst_n)
    cap_r |-> (pass_r == PASS_MAX))
    else $error("cap flag set without saturated pass count");

  // Every commit advances the pass counter by exactly one unless saturated.
  a_pass_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT && pass_r != PASS_MAX) |=> (pass_r == $past(pass_r) + 1))
    else $error("pass counter did not advance on commit");

  // A run leaves the pass loop only after a stable or saturated check.
  a_run_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CALC && !run_done) |=> (state_r == S_COMMIT))
    else $error("run left the pass loop early");

  // A result is posted only from the finish state.
  a_post_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FINISH))
    else $error("result posted outside finish state");

endmodule

`default_nettype wire

// ===== sim/tb_heat_stencil_relaxation.sv =====
`default_nettype none

// Testbench for the one-dimensional heat relaxation block.
//
// Items enter as commands: a start fills a vector with the boundary heat at
// element zero and zeros elsewhere, then runs Jacobi passes until no interior
// element moves by more than the tolerance or the pass count saturates. A
// read returns one element of the latest pass with the pass count and the
// saturation flag of that run. Every command yields exactly one result item.
//
// The bench keeps its own copy of the vector and of the three registers. When
// an item is taken by the block, the feeder works out the answer and appends
// it to the answer queue. The checker pops the oldest answer for every result
// item and compares the value, the pass count and the flag one by one.
//
// Registers are only written while nothing is in flight. The run starts with
// a short directed section (lengths of two and three, clamped lengths, zero
// and maximum heat, zero and maximum tolerance, reads at and past the end of
// the vector) and then runs a series of random sections. Each random section
// picks a new setting, opens with a start and then mixes mostly reads with
// the odd start. Sections rotate through four traffic shapes: free flow, a
// sparse sender, a slow receiver and light gaps on both sides. One section
// also holds the receiver off for a long stretch so the block backs up.
module tb_heat_stencil_relaxation;
  import hsr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RESET_CYCLES   = 9;
  localparam int          HOLD_CYCLES    = 900;
  localparam int          DRAIN_CYCLES   = 400;
  localparam int          RANDOM_PHASES  = 12;
  localparam int          PHASE_ITEMS    = 110;
  localparam int          MAX_REPORTS    = 10;
  localparam longint      TIMEOUT_NS     = 64'd60_000_000;
  // The block decodes a two-bit register index; index three has no register.
  localparam logic [1:0]  REG_SPARE      = 2'd3;

  // One command as the bench sees it, and one result with its three fields.
  typedef struct packed {
    hsr_cmd_t         cmd;
    logic [IDX_W-1:0] index;
  } heat_cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] passes;
    logic             cap_hit;
  } heat_answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [6:0] index, [7] zero fill
  logic [0:0]  in_tuser = '0;   // [0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;       // [31:0] value, [63:32] passes, [64] pass_cap_hit
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  heat_stencil_relaxation u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Commands waiting to be offered, and answers waiting for their result item.
  heat_cmd_t    cmd_queue[$];
  heat_answer_t answer_queue[$];

  // Traffic shape, in percent of cycles, set between sections.
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  // Long receiver hold-off: the stimulus raises hold_trigger for one cycle and
  // this counter keeps out_tready low until it runs out.
  logic hold_trigger = 1'b0;
  int   hold_left    = 0;

  // Shadow of the configuration registers, at their reset values.
  logic [7:0]       shadow_len  = 8'd100;
  logic [VAL_W-1:0] shadow_tol  = 32'd6554;
  logic [15:0]      shadow_heat = 16'd100;

  // Shadow of the vector and of the last run. Before any run the length is
  // zero, so every element is out of range.
  logic [VAL_W-1:0] heat_cells [MAX_LEN];
  logic [VAL_W-1:0] prev_cells [MAX_LEN];
  logic [VAL_W-1:0] run_passes = '0;
  logic             run_capped = 1'b0;
  int               run_len    = 0;

  int          bad_fields   = 0;
  int          results_seen = 0;
  int          runs_taken   = 0;
  int          reads_taken  = 0;
  logic [31:0] longest_run  = '0;

  // Works out the result of one command and moves the shadow state along.
  // A start relaxes the whole vector to convergence right here.
  task automatic compute_answer(input heat_cmd_t c, output heat_answer_t a);
    int               n;
    int               i;
    logic [SUM_W-1:0] sum;
    logic [VAL_W-1:0] avg;
    logic [VAL_W-1:0] delta;
    bit               settled;
    bit               done;
    if (c.cmd == CMD_START) begin
      // Lengths outside 2..MAX_LEN are clamped, not rejected.
      n = shadow_len;
      if (n < 2) n = 2;
      if (n > MAX_LEN) n = MAX_LEN;
      for (i = 0; i < n; i++) heat_cells[i] = '0;
      heat_cells[0] = {shadow_heat, 16'h0000};
      run_passes = '0;
      run_capped = 1'b0;
      run_len    = n;
      done       = 1'b0;
      while (!done) begin
        for (i = 0; i < n; i++) prev_cells[i] = heat_cells[i];
        settled = 1'b1;
        // With only two elements this loop is empty and the run settles at once.
        for (i = 1; i + 1 < n; i++) begin
          sum = {2'b00, prev_cells[i-1]} + {1'b0, prev_cells[i], 1'b0} +
                {2'b00, prev_cells[i+1]};
          avg = sum[SUM_W-1:2];
          delta = (avg >= prev_cells[i]) ? avg - prev_cells[i] : prev_cells[i] - avg;
          heat_cells[i] = avg;
          if (delta > shadow_tol) settled = 1'b0;
        end
        if (run_passes != '1) run_passes++;
        if (settled) begin
          done = 1'b1;
        end else if (run_passes == '1) begin
          // The counter saturated before the vector settled.
          run_capped = 1'b1;
          done = 1'b1;
        end
      end
      a.value = '0;
      runs_taken++;
      if (run_passes > longest_run) longest_run = run_passes;
    end else begin
      a.value = (int'(c.index) < run_len) ? heat_cells[c.index] : '0;
      reads_taken++;
    end
    a.passes  = run_passes;
    a.cap_hit = run_capped;
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    bad_fields++;
    if (bad_fields <= MAX_REPORTS)
      $display("[%0t] result %0d: %s expected 0x%08h, got 0x%08h",
               $realtime, results_seen, field, want, got);
  endtask

  // Feeder. Holds tvalid until the item is taken; when the channel is free it
  // offers the next command unless this cycle is chosen as a gap. The answer
  // is computed at the edge where the block takes the item.
  always @(posedge clk) begin : feed_items
    heat_cmd_t    taken;
    heat_cmd_t    next_cmd;
    heat_answer_t answer;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        taken.cmd   = hsr_cmd_t'(in_tuser[0]);
        taken.index = in_tdata[IDX_W-1:0];
        compute_answer(taken, answer);
        answer_queue.push_back(answer);
      end
      if (!in_tvalid || in_tready) begin
        if (cmd_queue.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
          next_cmd = cmd_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {1'b0, next_cmd.index};
          in_tuser  <= next_cmd.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : hold_counter
    if (hold_trigger) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Checker. Every result item is matched against the oldest answer; a result
  // with nothing waiting is an error of its own.
  always @(posedge clk) begin : check_results
    heat_answer_t got;
    heat_answer_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.value   = out_tdata[31:0];
        got.passes  = out_tdata[63:32];
        got.cap_hit = out_tdata[64];
        results_seen++;
        if (answer_queue.size() == 0) begin
          bad_fields++;
          if (bad_fields <= MAX_REPORTS)
            $display("[%0t] result %0d arrived with none outstanding: value 0x%08h",
                     $realtime, results_seen, got.value);
        end else begin
          want = answer_queue.pop_front();
          if (got.value !== want.value) note_mismatch("value", want.value, got.value);
          if (got.passes !== want.passes) note_mismatch("passes", want.passes, got.passes);
          if (got.cap_hit !== want.cap_hit)
            note_mismatch("pass_cap_hit", {31'd0, want.cap_hit}, {31'd0, got.cap_hit});
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Register write: one cycle with cfg_we high. The shadow follows with the
  // same masking the register widths imply; index three is ignored.
  task automatic write_reg(input logic [1:0] addr, input logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      REG_LENGTH: shadow_len  = data[7:0];
      REG_TOL:    shadow_tol  = data;
      REG_HEAT:   shadow_heat = data[15:0];
      default:    ;
    endcase
  endtask

  task automatic queue_cmd(input hsr_cmd_t cmd, input int idx);
    heat_cmd_t c;
    c.cmd   = cmd;
    c.index = idx[IDX_W-1:0];
    cmd_queue.push_back(c);
  endtask

  // Waits, sampling between edges, until every command has been taken and
  // every answer has been matched.
  task automatic wait_idle();
    do @(negedge clk);
    while (cmd_queue.size() != 0 || in_tvalid || answer_queue.size() != 0);
  endtask

  initial begin : stimulus
    int          phase;
    int          k;
    int          eff_len;
    int          read_len;
    logic [7:0]  len_w;
    logic [15:0] heat_w;
    logic [31:0] tol_w;
    logic [31:0] tol_floor;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed section, free flowing. Reads here always follow a start.
    // Reset setting: length 100, so reads at 100 and 127 fall past the end.
    queue_cmd(CMD_START, 0);
    queue_cmd(CMD_READ, 0);
    queue_cmd(CMD_READ, 1);
    queue_cmd(CMD_READ, 50);
    queue_cmd(CMD_READ, 99);
    queue_cmd(CMD_READ, 100);
    queue_cmd(CMD_READ, 127);
    wait_idle();

    // Two elements leave no interior, so one pass settles it even at zero
    // tolerance and full heat.
    write_reg(REG_LENGTH, 32'd2);
    write_reg(REG_TOL, 32'd0);
    write_reg(REG_HEAT, 32'd65535);
    @(negedge clk);
    queue_cmd(CMD_START, 0);
    queue_cmd(CMD_READ, 0);
    queue_cmd(CMD_READ, 1);
    queue_cmd(CMD_READ, 2);
    wait_idle();

    // One interior element at zero tolerance: it climbs to half the heat.
    write_reg(REG_LENGTH, 32'd3);
    @(negedge clk);
    queue_cmd(CMD_START, 0);
    queue_cmd(CMD_READ, 1);
    queue_cmd(CMD_READ, 3);
    wait_idle();

    // Length past the maximum is clamped; the widest tolerance stops after one
    // pass. The write to the unused index must change nothing.
    write_reg(REG_LENGTH, 32'd255);
    write_reg(REG_TOL, 32'hFFFF_FFFF);
    write_reg(REG_SPARE, 32'h0000_0001);
    @(negedge clk);
    queue_cmd(CMD_START, 0);
    queue_cmd(CMD_READ, 0);
    queue_cmd(CMD_READ, 1);
    queue_cmd(CMD_READ, 127);
    wait_idle();

    // Length zero is clamped up to two; no heat at all.
    write_reg(REG_LENGTH, 32'd0);
    write_reg(REG_HEAT, 32'd0);
    write_reg(REG_TOL, 32'd0);
    @(negedge clk);
    queue_cmd(CMD_START, 0);
    queue_cmd(CMD_READ, 0);
    wait_idle();

    // Full length with full heat and a moderate tolerance: a long run.
    write_reg(REG_LENGTH, MAX_LEN);
    write_reg(REG_HEAT, 32'd65535);
    write_reg(REG_TOL, 32'h0010_0000);
    @(negedge clk);
    queue_cmd(CMD_START, 0);
    queue_cmd(CMD_READ, 64);
    queue_cmd(CMD_READ, 126);
    wait_idle();

    // Random sections. Each gets a fresh setting and opens with a start.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(5, 0))
        0:       len_w = 8'($urandom_range(4, 2));
        1:       len_w = 8'($urandom_range(1, 0));
        2:       len_w = 8'($urandom_range(255, MAX_LEN + 1));
        3:       len_w = 8'(MAX_LEN);
        default: len_w = 8'($urandom_range(MAX_LEN - 1, 5));
      endcase
      eff_len = (len_w < 2) ? 2 : (len_w > MAX_LEN) ? MAX_LEN : len_w;
      case ($urandom_range(3, 0))
        0:       heat_w = 16'd0;
        1:       heat_w = 16'hFFFF;
        default: heat_w = 16'($urandom);
      endcase
      case ($urandom_range(4, 0))
        0:       tol_w = 32'd0;
        1:       tol_w = 32'hFFFF_FFFF;
        2:       tol_w = $urandom_range(65535, 0);
        default: tol_w = $urandom;
      endcase
      // Long vectors converge slowly: the number of passes grows roughly as
      // the heat over the tolerance. Keep that ratio below a few thousand so
      // a run stays short. Short vectors settle fast even at zero tolerance.
      if (eff_len > 8) begin
        tol_floor = {heat_w, 16'h0000} >> 12;
        if (tol_w < tol_floor) tol_w = tol_floor + $urandom_range(tol_floor, 0);
      end

      // Upper bits of the narrow registers carry noise; the block drops them.
      write_reg(REG_HEAT, ($urandom & 32'hFFFF_0000) | {16'h0000, heat_w});
      write_reg(REG_LENGTH, ($urandom & 32'hFFFF_FF00) | {24'h0, len_w});
      write_reg(REG_TOL, tol_w);
      if ($urandom_range(3, 0) == 0) write_reg(REG_SPARE, $urandom);

      case (phase % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin sender_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      @(negedge clk);

      queue_cmd(CMD_START, 0);
      read_len = eff_len;
      for (k = 1; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(19, 0) == 0) begin
          queue_cmd(CMD_START, 0);
        end else if ($urandom_range(4, 0) != 0) begin
          queue_cmd(CMD_READ, $urandom_range(read_len - 1, 0));
        end else begin
          queue_cmd(CMD_READ, $urandom_range(MAX_LEN - 1, 0));
        end
      end

      // In one free-flowing section the receiver stops for a long while
      // as the commands stream in, so the block fills and refuses input.
      if (phase == 4) begin
        @(posedge clk);
        hold_trigger <= 1'b1;
        @(posedge clk);
        hold_trigger <= 1'b0;
      end
      wait_idle();
    end

    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d starts and %0d reads over %0d random settings; %0d results checked.",
             runs_taken, reads_taken, RANDOM_PHASES, results_seen);
    $display("Longest run took %0d passes; %0d field mismatches.", longest_run, bad_fields);
    if (bad_fields == 0) begin
      $display("tb_heat_stencil_relaxation: done, clean");
    end else begin
      $display("tb_heat_stencil_relaxation: done, errors");
    end
    $finish;
  end

  // Guard against a hung block: far beyond the slowest correct run.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timed out with %0d commands unsent and %0d results outstanding.",
             cmd_queue.size(), answer_queue.size());
    $display("tb_heat_stencil_relaxation: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
